[rtl/core/svcov_pkg.sv]
`default_nettype none
package svcov_pkg;

   // input operation codes
   typedef enum logic [1:0] {
      OP_START  = 2'd0,
      OP_ELEM   = 2'd1,
      OP_FINISH = 2'd2
   } op_type;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_BUDGET  = 2'd0,
      CSR_LARGEST = 2'd1,
      CSR_EPSILON = 2'd2
   } csr_idx_type;

   // fixed field widths
   localparam int OP_W      = 2;
   localparam int ID_W      = 16;
   localparam int ELEM_W    = 12;
   localparam int BUDGET_W  = 7;
   localparam int LSS_W     = 9;
   localparam int EPS_W     = 16;
   localparam int CSR_W     = 16;
   localparam int COV_OUT_W = 13;
   localparam int SPACE_W   = 18;

   // guess ladder in Q18.8, one fractional byte
   localparam int GUESS_W   = 26;
   localparam int FRAC_W    = 8;
   // width of the acceptance compare
   localparam int CMP_W     = 40;

   // sequencer states, one-hot
   typedef enum logic [17:0] {
      ST_IDLE   = 18'h00001,
      ST_RED    = 18'h00002,
      ST_ADD_RD = 18'h00004,
      ST_ADD_UP = 18'h00008,
      ST_CL_RD  = 18'h00010,
      ST_CL_EV  = 18'h00020,
      ST_MK_A   = 18'h00040,
      ST_MK_B   = 18'h00080,
      ST_MK_C   = 18'h00100,
      ST_MK_D   = 18'h00200,
      ST_LOW    = 18'h00400,
      ST_HIGH   = 18'h00800,
      ST_CLR    = 18'h01000,
      ST_RP_RD  = 18'h02000,
      ST_RP_EV  = 18'h04000,
      ST_RP_END = 18'h08000,
      ST_PK_RD  = 18'h10000,
      ST_EMIT   = 18'h20000
   } state_type;

endpackage
`default_nettype wire

[rtl/core/svcov_ram.sv]
`default_nettype none
module svcov_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule
`default_nettype wire

[rtl/core/sieve_streaming_max_cover.sv]
`default_nettype none
// Channel   Direction  Handshake              Payload
// req       in         req_valid/req_ready    operation, set_id, element, last_of_set
// rsp       out        rsp_valid/rsp_ready    chosen_set .. last
// csr       in         csr_wr_en              csr_index, csr_write_data
//
// One item at a time; req_ready is high only while the sequencer is idle.
// Reset loads budget 8, largest set size 64 and epsilon 6554 and leaves no guess active.
// Element: modulo reduction (one subtract a cycle), then a read and an update of each
// active guess through the single guess-state memory port. Set close: each guess is
// read and tested; each guess that takes the set marks every buffered element.
// Start: one ladder step per cycle, then a clear of the bitmaps of all active guesses.
// Finish: each guess is read and summed, then each result is read and held until rsp_ready.
module sieve_streaming_max_cover #(
   parameter int UNIVERSE    = 4096,
   parameter int NUM_GUESSES = 32,
   parameter int MAX_BUDGET  = 64,
   parameter int MAX_SET_LEN = 256
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_ready,
   input  wire logic [svcov_pkg::OP_W-1:0]      req_operation,
   input  wire logic [svcov_pkg::ID_W-1:0]      req_set_id,
   input  wire logic [svcov_pkg::ELEM_W-1:0]    req_element,
   input  wire logic                            req_last_of_set,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_ready,
   output logic      [svcov_pkg::ID_W-1:0]      rsp_chosen_set,
   output logic                                 rsp_index_valid,
   output logic      [svcov_pkg::COV_OUT_W-1:0] rsp_cover_count,
   output logic      [svcov_pkg::SPACE_W-1:0]   rsp_space_used,
   output logic                                 rsp_guesses_dropped,
   output logic                                 rsp_last,
   input  wire logic                            csr_wr_en,
   input  wire logic [1:0]                      csr_index,
   input  wire logic [svcov_pkg::CSR_W-1:0]     csr_write_data
);

   localparam int EW    = $clog2(UNIVERSE);
   localparam int EXT_W = (EW > svcov_pkg::ELEM_W) ? EW : svcov_pkg::ELEM_W;
   localparam int GW    = $clog2(NUM_GUESSES);
   localparam int AW    = $clog2(NUM_GUESSES + 1);
   localparam int CW    = $clog2(UNIVERSE + 1);
   localparam int CX_W  = (CW > svcov_pkg::COV_OUT_W) ? CW : svcov_pkg::COV_OUT_W;
   localparam int PCW   = $clog2(MAX_BUDGET + 1);
   localparam int PIW   = (MAX_BUDGET > 1) ? $clog2(MAX_BUDGET) : 1;
   localparam int NW    = $clog2(MAX_SET_LEN + 1);
   localparam int SBW   = $clog2(MAX_SET_LEN);
   localparam int VW    = svcov_pkg::GUESS_W;
   localparam int MW    = GW + EW;
   localparam int IW    = GW + PIW;

   typedef struct packed {
      logic [VW-1:0]  v;
      logic [CW-1:0]  cov;
      logic [PCW-1:0] pick;
      logic [NW-1:0]  newc;
   } gword_type;

   localparam int GWORD_W = $bits(gword_type);

   svcov_pkg::state_type state_ff;

   // configuration
   logic [svcov_pkg::BUDGET_W-1:0] budget_ff;
   logic [svcov_pkg::LSS_W-1:0]    lss_ff;
   logic [svcov_pkg::EPS_W-1:0]    eps_ff;

   // pass state
   logic [AW-1:0]  active_ff;
   logic           drop_ff;
   logic [NW-1:0]  setlen_ff;

   // item and loop registers
   logic [svcov_pkg::ID_W-1:0]   sid_ff;
   logic                         last_ff;
   logic [svcov_pkg::ELEM_W-1:0] red_ff;
   logic [EW-1:0]                elem_ff;
   logic [AW-1:0]                g_ff;
   logic [NW-1:0]                i_ff;
   logic [VW-1:0]                v_ff;
   logic [VW-1:0]                low_ff;
   logic [VW-1:0]                high_ff;
   logic [AW+EW-1:0]             clr_ff;
   gword_type                    work_ff;
   logic [CW-1:0]                covacc_ff;
   logic [svcov_pkg::SPACE_W-1:0] space_ff;
   logic [CW-1:0]                bestcov_ff;
   logic [GW-1:0]                bestg_ff;
   logic [PCW-1:0]               bestp_ff;
   logic [PCW-1:0]               r_ff;

   // result register
   logic                            rvalid_ff;
   logic [svcov_pkg::ID_W-1:0]      rchosen_ff;
   logic                            rindex_ff;
   logic [svcov_pkg::COV_OUT_W-1:0] rcov_ff;
   logic [svcov_pkg::SPACE_W-1:0]   rspace_ff;
   logic                            rdrop_ff;
   logic                            rlast_ff;

   // memory ports
   logic            g_wr_en;
   logic [GW-1:0]   g_wr_addr;
   gword_type       g_wr_data;
   gword_type       g_rd_data;
   logic [GWORD_W-1:0] g_rd_bits;
   logic            m_wr_en;
   logic [MW-1:0]   m_wr_addr;
   logic            m_wr_data;
   logic            m_rd_data;
   logic            s_wr_en;
   logic [EW-1:0]   s_rd_data;
   logic            p_wr_en;
   logic [svcov_pkg::ID_W-1:0] p_rd_data;

   // effective budget, growth step, acceptance test
   logic [svcov_pkg::BUDGET_W-1:0] k_eff;
   logic [VW+15:0]                 gprod;
   logic [VW:0]                    gsum;
   logic [VW-1:0]                  grown;
   logic [EXT_W-1:0]               red_ext;
   logic                           p_lt_k;
   logic [svcov_pkg::BUDGET_W-1:0] k_minus_p;
   logic signed [svcov_pkg::CMP_W-1:0] lhs;
   logic signed [svcov_pkg::CMP_W-1:0] rhs;
   logic                           take;
   logic [CX_W-1:0]                bestcov_ext;

   assign g_rd_data = gword_type'(g_rd_bits);

   always_comb begin
      if (32'(budget_ff) > 32'(MAX_BUDGET)) begin
         k_eff = svcov_pkg::BUDGET_W'(MAX_BUDGET);
      end else begin
         k_eff = budget_ff;
      end
   end

   // v + floor(v*eps/65536), at least one LSB up
   assign gprod = (VW + 16)'(v_ff) * (VW + 16)'(eps_ff);
   assign gsum  = {1'b0, v_ff} + (VW + 1)'(gprod[VW+15:16]);
   assign grown = (gsum > {1'b0, v_ff}) ? gsum[VW-1:0] : v_ff + VW'(1);

   assign red_ext = EXT_W'(red_ff);

   assign p_lt_k    = 32'(g_rd_data.pick) < 32'(k_eff);
   assign k_minus_p = k_eff - svcov_pkg::BUDGET_W'(g_rd_data.pick);
   assign lhs = $signed(svcov_pkg::CMP_W'(16'(g_rd_data.newc) * 16'(k_minus_p)) << 9);
   assign rhs = $signed(svcov_pkg::CMP_W'(g_rd_data.v))
              - $signed(svcov_pkg::CMP_W'(g_rd_data.cov) << 9);
   assign take = p_lt_k && (lhs >= rhs);

   assign bestcov_ext = CX_W'(bestcov_ff);

   // guess-state write port
   always_comb begin
      g_wr_en   = 1'b0;
      g_wr_addr = g_ff[GW-1:0];
      g_wr_data = g_rd_data;
      unique case (state_ff)
         svcov_pkg::ST_HIGH: begin
            g_wr_en   = (v_ff <= high_ff) && (32'(active_ff) < 32'(NUM_GUESSES));
            g_wr_addr = active_ff[GW-1:0];
            g_wr_data = '{v: v_ff, cov: '0, pick: '0, newc: '0};
         end
         svcov_pkg::ST_ADD_UP: begin
            g_wr_en        = !m_rd_data;
            g_wr_data.newc = g_rd_data.newc + NW'(1);
         end
         svcov_pkg::ST_CL_EV: begin
            g_wr_en        = !take;
            g_wr_data.newc = '0;
         end
         svcov_pkg::ST_MK_A: begin
            g_wr_en   = (i_ff == setlen_ff);
            g_wr_data = '{v: work_ff.v, cov: covacc_ff,
                          pick: work_ff.pick + PCW'(1), newc: '0};
         end
         default: begin
            g_wr_en = 1'b0;
         end
      endcase
   end

   // bitmap write port: clear sweep or mark
   always_comb begin
      if (state_ff == svcov_pkg::ST_CLR) begin
         m_wr_en   = (clr_ff != {active_ff, {EW{1'b0}}});
         m_wr_addr = clr_ff[MW-1:0];
         m_wr_data = 1'b0;
      end else begin
         m_wr_en   = (state_ff == svcov_pkg::ST_MK_D) && !m_rd_data;
         m_wr_addr = {g_ff[GW-1:0], elem_ff};
         m_wr_data = 1'b1;
      end
   end

   assign s_wr_en = (state_ff == svcov_pkg::ST_RED) && (32'(red_ff) < 32'(UNIVERSE));
   assign p_wr_en = (state_ff == svcov_pkg::ST_CL_EV) && take;

   svcov_ram #(.WIDTH(GWORD_W), .DEPTH(NUM_GUESSES)) u_guess_ram (
      .clock   (clock),
      .wr_en   (g_wr_en),
      .wr_addr (g_wr_addr),
      .wr_data (GWORD_W'(g_wr_data)),
      .rd_addr (g_ff[GW-1:0]),
      .rd_data (g_rd_bits)
   );

   svcov_ram #(.WIDTH(1), .DEPTH(NUM_GUESSES * (2 ** EW))) u_map_ram (
      .clock   (clock),
      .wr_en   (m_wr_en),
      .wr_addr (m_wr_addr),
      .wr_data (m_wr_data),
      .rd_addr ({g_ff[GW-1:0], elem_ff}),
      .rd_data (m_rd_data)
   );

   svcov_ram #(.WIDTH(EW), .DEPTH(MAX_SET_LEN)) u_set_ram (
      .clock   (clock),
      .wr_en   (s_wr_en),
      .wr_addr (setlen_ff[SBW-1:0]),
      .wr_data (red_ext[EW-1:0]),
      .rd_addr (i_ff[SBW-1:0]),
      .rd_data (s_rd_data)
   );

   svcov_ram #(.WIDTH(svcov_pkg::ID_W), .DEPTH(NUM_GUESSES * (2 ** PIW))) u_pick_ram (
      .clock   (clock),
      .wr_en   (p_wr_en),
      .wr_addr (IW'({g_ff[GW-1:0], g_rd_data.pick[PIW-1:0]})),
      .wr_data (sid_ff),
      .rd_addr (IW'({bestg_ff, r_ff[PIW-1:0]})),
      .rd_data (p_rd_data)
   );

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         budget_ff <= svcov_pkg::BUDGET_W'(8);
         lss_ff    <= svcov_pkg::LSS_W'(64);
         eps_ff    <= svcov_pkg::EPS_W'(6554);
      end else if (csr_wr_en) begin
         case (csr_index)
            svcov_pkg::CSR_BUDGET:  budget_ff <= csr_write_data[svcov_pkg::BUDGET_W-1:0];
            svcov_pkg::CSR_LARGEST: lss_ff    <= csr_write_data[svcov_pkg::LSS_W-1:0];
            svcov_pkg::CSR_EPSILON: eps_ff    <= csr_write_data[svcov_pkg::EPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= svcov_pkg::ST_IDLE;
         active_ff <= '0;
         drop_ff   <= 1'b0;
         setlen_ff <= '0;
         rvalid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            svcov_pkg::ST_IDLE: begin
               if (req_valid) begin
                  sid_ff  <= req_set_id;
                  last_ff <= req_last_of_set;
                  red_ff  <= req_element;
                  g_ff    <= '0;
                  case (req_operation)
                     svcov_pkg::OP_START: begin
                        v_ff      <= VW'(1 << svcov_pkg::FRAC_W);
                        low_ff    <= VW'(lss_ff) << svcov_pkg::FRAC_W;
                        high_ff   <= VW'(VW'(k_eff) * VW'(lss_ff)) << (svcov_pkg::FRAC_W + 1);
                        active_ff <= '0;
                        drop_ff   <= 1'b0;
                        setlen_ff <= '0;
                        state_ff  <= svcov_pkg::ST_LOW;
                     end
                     svcov_pkg::OP_ELEM: begin
                        if (32'(setlen_ff) < 32'(MAX_SET_LEN)) begin
                           state_ff <= svcov_pkg::ST_RED;
                        end else if (req_last_of_set) begin
                           state_ff <= svcov_pkg::ST_CL_RD;
                        end
                     end
                     svcov_pkg::OP_FINISH: begin
                        space_ff   <= '0;
                        bestcov_ff <= '0;
                        bestg_ff   <= '0;
                        bestp_ff   <= '0;
                        state_ff   <= svcov_pkg::ST_RP_RD;
                     end
                     default: begin
                     end
                  endcase
               end
            end
            // reduce the element into the universe, then buffer it
            svcov_pkg::ST_RED: begin
               if (32'(red_ff) >= 32'(UNIVERSE)) begin
                  red_ff <= red_ff - svcov_pkg::ELEM_W'(UNIVERSE);
               end else begin
                  elem_ff   <= red_ext[EW-1:0];
                  setlen_ff <= setlen_ff + NW'(1);
                  state_ff  <= svcov_pkg::ST_ADD_RD;
               end
            end
            svcov_pkg::ST_ADD_RD: begin
               if (g_ff == active_ff) begin
                  g_ff     <= '0;
                  state_ff <= last_ff ? svcov_pkg::ST_CL_RD : svcov_pkg::ST_IDLE;
               end else begin
                  state_ff <= svcov_pkg::ST_ADD_UP;
               end
            end
            svcov_pkg::ST_ADD_UP: begin
               g_ff     <= g_ff + AW'(1);
               state_ff <= svcov_pkg::ST_ADD_RD;
            end
            // close the set: test each guess
            svcov_pkg::ST_CL_RD: begin
               if (g_ff == active_ff) begin
                  setlen_ff <= '0;
                  state_ff  <= svcov_pkg::ST_IDLE;
               end else begin
                  state_ff <= svcov_pkg::ST_CL_EV;
               end
            end
            svcov_pkg::ST_CL_EV: begin
               work_ff   <= g_rd_data;
               covacc_ff <= g_rd_data.cov;
               i_ff      <= '0;
               if (take) begin
                  state_ff <= svcov_pkg::ST_MK_A;
               end else begin
                  g_ff     <= g_ff + AW'(1);
                  state_ff <= svcov_pkg::ST_CL_RD;
               end
            end
            // mark buffered elements in this guess's bitmap
            svcov_pkg::ST_MK_A: begin
               if (i_ff == setlen_ff) begin
                  g_ff     <= g_ff + AW'(1);
                  state_ff <= svcov_pkg::ST_CL_RD;
               end else begin
                  state_ff <= svcov_pkg::ST_MK_B;
               end
            end
            svcov_pkg::ST_MK_B: begin
               elem_ff  <= s_rd_data;
               state_ff <= svcov_pkg::ST_MK_C;
            end
            svcov_pkg::ST_MK_C: begin
               state_ff <= svcov_pkg::ST_MK_D;
            end
            svcov_pkg::ST_MK_D: begin
               if (!m_rd_data) begin
                  covacc_ff <= covacc_ff + CW'(1);
               end
               i_ff     <= i_ff + NW'(1);
               state_ff <= svcov_pkg::ST_MK_A;
            end
            // guess ladder
            svcov_pkg::ST_LOW: begin
               if (v_ff < low_ff) begin
                  v_ff <= grown;
               end else begin
                  state_ff <= svcov_pkg::ST_HIGH;
               end
            end
            svcov_pkg::ST_HIGH: begin
               clr_ff <= '0;
               if (v_ff > high_ff) begin
                  state_ff <= svcov_pkg::ST_CLR;
               end else if (32'(active_ff) >= 32'(NUM_GUESSES)) begin
                  drop_ff  <= 1'b1;
                  state_ff <= svcov_pkg::ST_CLR;
               end else begin
                  active_ff <= active_ff + AW'(1);
                  v_ff      <= grown;
               end
            end
            svcov_pkg::ST_CLR: begin
               if (clr_ff == {active_ff, {EW{1'b0}}}) begin
                  state_ff <= svcov_pkg::ST_IDLE;
               end else begin
                  clr_ff <= clr_ff + (AW + EW)'(1);
               end
            end
            // report: find best guess and total space
            svcov_pkg::ST_RP_RD: begin
               state_ff <= (g_ff == active_ff) ? svcov_pkg::ST_RP_END : svcov_pkg::ST_RP_EV;
            end
            svcov_pkg::ST_RP_EV: begin
               space_ff <= space_ff + svcov_pkg::SPACE_W'(g_rd_data.cov);
               if ((g_ff == '0) || (g_rd_data.cov > bestcov_ff)) begin
                  bestcov_ff <= g_rd_data.cov;
                  bestg_ff   <= g_ff[GW-1:0];
                  bestp_ff   <= g_rd_data.pick;
               end
               g_ff     <= g_ff + AW'(1);
               state_ff <= svcov_pkg::ST_RP_RD;
            end
            svcov_pkg::ST_RP_END: begin
               rcov_ff   <= bestcov_ext[svcov_pkg::COV_OUT_W-1:0];
               rspace_ff <= space_ff;
               rdrop_ff  <= drop_ff;
               r_ff      <= '0;
               if (bestp_ff == '0) begin
                  rindex_ff  <= 1'b0;
                  rlast_ff   <= 1'b1;
                  rvalid_ff  <= 1'b1;
                  state_ff   <= svcov_pkg::ST_EMIT;
               end else begin
                  state_ff <= svcov_pkg::ST_PK_RD;
               end
            end
            svcov_pkg::ST_PK_RD: begin
               state_ff <= svcov_pkg::ST_EMIT;
               rvalid_ff <= 1'b1;
               rindex_ff <= 1'b1;
               rlast_ff  <= (r_ff + PCW'(1)) == bestp_ff;
            end
            svcov_pkg::ST_EMIT: begin
               if (rsp_ready) begin
                  rvalid_ff <= 1'b0;
                  r_ff      <= r_ff + PCW'(1);
                  state_ff  <= rlast_ff ? svcov_pkg::ST_IDLE : svcov_pkg::ST_PK_RD;
               end
            end
            default: begin
               state_ff <= svcov_pkg::ST_IDLE;
            end
         endcase
      end
   end

   // chosen id arrives from the pick memory in the cycle after its read
   logic pick_show_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         pick_show_ff <= 1'b0;
      end else begin
         pick_show_ff <= (state_ff == svcov_pkg::ST_PK_RD);
      end
   end

   logic [svcov_pkg::ID_W-1:0] chosen_out;
   assign chosen_out = pick_show_ff ? p_rd_data : rchosen_ff;

   always_ff @(posedge clock) begin
      if (pick_show_ff) begin
         rchosen_ff <= p_rd_data;
      end
   end

   assign req_ready           = (state_ff == svcov_pkg::ST_IDLE);
   assign rsp_valid           = rvalid_ff;
   assign rsp_chosen_set      = rindex_ff ? chosen_out : '0;
   assign rsp_index_valid     = rindex_ff;
   assign rsp_cover_count     = rcov_ff;
   assign rsp_space_used      = rspace_ff;
   assign rsp_guesses_dropped = rdrop_ff;
   assign rsp_last            = rlast_ff;

endmodule
`default_nettype wire
